### hw/rtl/led_blink_pattern_engine_top_macros.svh
// assertion macros for the led blink pattern engine checker
`ifndef LED_BLINK_PATTERN_ENGINE_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_ENGINE_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define LBPE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define LBPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### hw/rtl/lbpe_pkg.sv
// types, constants and helper functions shared by the led blink pattern engine
package lbpe_pkg;

   localparam int NUM_LEDS_DEF = 8;
   localparam int MAX_STEPS    = 8;
   localparam int MAX_ROWS     = 4;
   localparam int NUM_ROW_REGS = 4;

   localparam logic [63:0] ROW0_RESET = 64'h0A05_0A05_0A05_0A05;
   localparam logic [63:0] ROW1_RESET = 64'h0202_0202_0202_0202;
   localparam logic [63:0] ROW2_RESET = 64'h0A0A_0A0A_0A0A_0A0A;
   localparam logic [63:0] ROW3_RESET = 64'h000A_0A0A_0A0A_0A0A;
   localparam logic [2:0]  ROWS_IN_USE_RESET  = 3'd3;
   localparam logic [3:0]  STEPS_IN_USE_RESET = 4'd8;

   // request kinds
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_CMD    = 2'd1;
   localparam logic [1:0] REQ_SELECT = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_ROW_ZERO     = 3'd0;
   localparam logic [2:0] CSR_ROW_ONE      = 3'd1;
   localparam logic [2:0] CSR_ROW_TWO      = 3'd2;
   localparam logic [2:0] CSR_ROW_THREE    = 3'd3;
   localparam logic [2:0] CSR_ROWS_IN_USE  = 3'd4;
   localparam logic [2:0] CSR_STEPS_IN_USE = 3'd5;

   // mode commands
   localparam logic [2:0] CMD_STANDBY = 3'd0;
   localparam logic [2:0] CMD_ON      = 3'd1;
   localparam logic [2:0] CMD_OFF     = 3'd2;
   localparam logic [2:0] CMD_FLASH   = 3'd3;
   localparam logic [2:0] CMD_DISABLE = 3'd4;
   localparam logic [2:0] CMD_ENABLE  = 3'd5;

   // mode machine inputs
   localparam logic [2:0] IN_STANDBY  = 3'd0;
   localparam logic [2:0] IN_ON       = 3'd1;
   localparam logic [2:0] IN_OFF      = 3'd2;
   localparam logic [2:0] IN_FLASH    = 3'd3;
   localparam logic [2:0] IN_FLASHOFF = 3'd4;
   localparam logic [2:0] IN_DISABLE  = 3'd5;
   localparam logic [2:0] IN_ENABLE   = 3'd6;

   // modes
   localparam logic [2:0] MODE_STANDBY   = 3'd0;
   localparam logic [2:0] MODE_ALWAYSON  = 3'd1;
   localparam logic [2:0] MODE_ALWAYSOFF = 3'd2;
   localparam logic [2:0] MODE_FLASHON   = 3'd3;
   localparam logic [2:0] MODE_FLASHOFF  = 3'd4;
   localparam logic [2:0] MODE_FLASHSTBY = 3'd5;
   localparam logic [2:0] MODE_DISABLED  = 3'd6;

   localparam logic [2:0] NEXT_MODE [7][7] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd6, 3'd0},
      '{3'd0, 3'd1, 3'd2, 3'd1, 3'd1, 3'd6, 3'd1},
      '{3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd6, 3'd2},
      '{3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd3},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd4},
      '{3'd5, 3'd1, 3'd2, 3'd5, 3'd0, 3'd6, 3'd5},
      '{3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd0}
   };

   typedef logic [NUM_ROW_REGS-1:0][63:0] rows_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] tick;
      logic [2:0] step;
      logic [1:0] row;
      logic [7:0] len;
   } led_rec_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] mode_input;
      logic [1:0] choice;
   } led_op_type;

   localparam led_rec_type LED_REC_RESET = '{
      mode: MODE_STANDBY, tick: 8'd0, step: 3'd0, row: 2'd0, len: ROW0_RESET[7:0]
   };

   function automatic logic [2:0] next_mode(input logic [2:0] m, input logic [2:0] in_code);
      logic [2:0] res;
      res = m;
      if (m != 3'd7 && in_code != 3'd7) begin
         res = NEXT_MODE[m][in_code];
      end
      return res;
   endfunction

   function automatic logic [2:0] cmd_to_input(input logic [2:0] cmd);
      logic [2:0] res;
      unique case (cmd)
         CMD_STANDBY: res = IN_STANDBY;
         CMD_ON:      res = IN_ON;
         CMD_OFF:     res = IN_OFF;
         CMD_FLASH:   res = IN_FLASH;
         CMD_DISABLE: res = IN_DISABLE;
         CMD_ENABLE:  res = IN_ENABLE;
         default:     res = IN_STANDBY;
      endcase
      return res;
   endfunction

   function automatic logic cmd_known(input logic [2:0] cmd);
      return cmd == CMD_STANDBY || cmd == CMD_ON || cmd == CMD_OFF ||
             cmd == CMD_FLASH || cmd == CMD_DISABLE || cmd == CMD_ENABLE;
   endfunction

   function automatic logic lamp_on(input logic [2:0] m);
      return m == MODE_ALWAYSON || m == MODE_FLASHON || m == MODE_FLASHSTBY;
   endfunction

   function automatic logic is_flashing(input logic [2:0] m);
      return m == MODE_FLASHON || m == MODE_FLASHOFF || m == MODE_FLASHSTBY;
   endfunction

   function automatic logic [7:0] row_byte(input rows_type rows, input logic [1:0] row,
                                           input logic [2:0] step);
      return rows[row][{step, 3'b000} +: 8];
   endfunction

endpackage

### hw/rtl/lbpe_step_unit.sv
// next value of one led record for a tick, a mode command or a pattern select
module lbpe_step_unit
   import lbpe_pkg::*;
(
   input  led_op_type  op,
   input  led_rec_type rec_cur,
   input  rows_type    rows,
   input  logic [3:0]  steps_in_use,
   output led_rec_type rec_new
);

   logic [3:0] limit;
   logic [3:0] step_inc;
   logic [2:0] step_nx;
   logic [7:0] tick_inc;
   logic [7:0] len_nx;
   logic [2:0] mode_a;
   logic [2:0] mode_tick;

   assign limit    = (steps_in_use < 4'(MAX_STEPS)) ? steps_in_use : 4'(MAX_STEPS);
   assign step_inc = {1'b0, rec_cur.step} + 4'd1;
   assign step_nx  = (step_inc >= limit) ? 3'd0 : step_inc[2:0];
   assign tick_inc = rec_cur.tick + 8'd1;
   assign len_nx   = row_byte(rows, rec_cur.row, step_nx);
   assign mode_a   = (len_nx == 8'd0) ? next_mode(rec_cur.mode, IN_STANDBY) : rec_cur.mode;
   assign mode_tick = (mode_a == MODE_FLASHOFF) ? next_mode(mode_a, IN_FLASH)
                                                : next_mode(mode_a, IN_FLASHOFF);

   always_comb begin
      rec_new = rec_cur;
      unique case (op.kind)
         REQ_TICK: begin
            if (is_flashing(rec_cur.mode)) begin
               if (tick_inc < rec_cur.len) begin
                  rec_new.tick = tick_inc;
               end else begin
                  rec_new.tick = 8'd0;
                  rec_new.step = step_nx;
                  rec_new.len  = len_nx;
                  rec_new.mode = mode_tick;
               end
            end
         end
         REQ_CMD: begin
            rec_new.mode = next_mode(rec_cur.mode, op.mode_input);
         end
         REQ_SELECT: begin
            rec_new.tick = 8'd0;
            rec_new.row  = op.choice;
            rec_new.step = 3'd0;
            rec_new.len  = row_byte(rows, op.choice, 3'd0);
         end
         default: begin
            rec_new = rec_cur;
         end
      endcase
   end

endmodule

### hw/rtl/led_blink_pattern_engine_top.sv
// Blink pattern engine for NUM_LEDS leds. Each led's record (mode, tick count, step, row,
// step length) sits in a one-port-read, one-port-write synchronous RAM with a registered
// read, with a valid bit per entry so that reset takes effect at once. A tick request
// sweeps the RAM one led per cycle, reading the next record while writing back the current
// one. A mode command or pattern select reads, updates and writes one record; a refused or
// unknown request goes straight to the finish state. The result register lets a new request
// in while the previous response is still stalled. The user is to write registers through
// the csr port only while idle; the block itself does not enforce it.
module led_blink_pattern_engine_top
   import lbpe_pkg::*;
#(
   parameter int NUM_LEDS = NUM_LEDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_led_index,
   input  logic [2:0]  req_mode_command,
   input  logic [1:0]  req_pattern_choice,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_lamp_mask,
   output logic        rsp_pattern_accepted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int LedW  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int LampW = (NUM_LEDS > 8) ? NUM_LEDS : 8;
   localparam logic [LedW-1:0] LastLed = LedW'(NUM_LEDS - 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SWEEP  = 4'b0010,
      S_UPDATE = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   led_op_type  op_ff, op_in;
   logic [LedW-1:0] led_ff, led_in;
   logic [LedW-1:0] cnt_ff, cnt_in;
   logic        acc_ff, acc_in;

   rows_type    rows_ff;
   logic [2:0]  rows_in_use_ff;
   logic [3:0]  steps_in_use_ff;

   led_rec_type led_ram [NUM_LEDS];
   led_rec_type ram_rd_ff;
   logic        rd_vld_ff;
   logic [NUM_LEDS-1:0] valid_ff;
   logic [NUM_LEDS-1:0] lamp_ff;

   logic        rd_en;
   logic [LedW-1:0] rd_addr;
   logic        wr_en;
   logic [LedW-1:0] wr_addr;
   led_rec_type rec_cur;
   led_rec_type rec_new;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  mask_ff;
   logic        pacc_ff;
   logic [LampW-1:0] lamp_ext;
   logic        rsp_load;

   logic        req_take;
   logic [5:0]  led_wide;
   logic        led_ok;
   logic        cmd_ok;
   logic        sel_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign led_wide = 6'(req_led_index);
   assign led_ok   = led_wide < 6'(NUM_LEDS);
   assign cmd_ok   = led_ok && cmd_known(req_mode_command);
   assign sel_ok   = led_ok && ({1'b0, req_pattern_choice} < rows_in_use_ff) &&
                     (3'(req_pattern_choice) < 3'(MAX_ROWS));

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff[0]      <= ROW0_RESET;
         rows_ff[1]      <= ROW1_RESET;
         rows_ff[2]      <= ROW2_RESET;
         rows_ff[3]      <= ROW3_RESET;
         rows_in_use_ff  <= ROWS_IN_USE_RESET;
         steps_in_use_ff <= STEPS_IN_USE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_ZERO:     rows_ff[0]      <= csr_data;
            CSR_ROW_ONE:      rows_ff[1]      <= csr_data;
            CSR_ROW_TWO:      rows_ff[2]      <= csr_data;
            CSR_ROW_THREE:    rows_ff[3]      <= csr_data;
            CSR_ROWS_IN_USE:  rows_in_use_ff  <= csr_data[2:0];
            CSR_STEPS_IN_USE: steps_in_use_ff <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      led_in   = led_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      rd_en    = 1'b0;
      rd_addr  = cnt_ff;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in.kind       = req_type;
               op_in.mode_input = cmd_to_input(req_mode_command);
               op_in.choice     = req_pattern_choice;
               led_in           = led_wide[LedW-1:0];
               cnt_in           = '0;
               acc_in           = (req_type == REQ_SELECT) && sel_ok;
               if (req_type == REQ_TICK) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_SWEEP;
               end else if ((req_type == REQ_CMD && cmd_ok) ||
                            (req_type == REQ_SELECT && sel_ok)) begin
                  rd_en    = 1'b1;
                  rd_addr  = led_wide[LedW-1:0];
                  state_in = S_UPDATE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            if (cnt_ff == LastLed) begin
               state_in = S_FINISH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cnt_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         S_UPDATE: begin
            wr_en    = 1'b1;
            wr_addr  = led_ff;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      led_ff <= led_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
   end

   // record ram
   always_ff @(posedge clock) begin
      if (wr_en) begin
         led_ram[wr_addr] <= rec_new;
      end
      if (rd_en) begin
         ram_rd_ff <= led_ram[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         lamp_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
            lamp_ff[wr_addr]  <= lamp_on(rec_new.mode);
         end
      end
   end

   assign rec_cur = rd_vld_ff ? ram_rd_ff : LED_REC_RESET;

   lbpe_step_unit u_step (
      .op           (op_ff),
      .rec_cur      (rec_cur),
      .rows         (rows_ff),
      .steps_in_use (steps_in_use_ff),
      .rec_new      (rec_new)
   );

   // response register
   assign lamp_ext = LampW'(lamp_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         mask_ff <= lamp_ext[7:0];
         pacc_ff <= acc_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_lamp_mask        = mask_ff;
   assign rsp_pattern_accepted = pacc_ff;

endmodule

### hw/rtl/lbpe_checker.sv
// port-level checks for the led blink pattern engine, bound to the top level
`include "led_blink_pattern_engine_top_macros.svh"

module lbpe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_lamp_mask,
   input logic       rsp_pattern_accepted
);

   // a taken request makes the engine busy in the next cycle
   `LBPE_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

   // a new response only appears at the end of a busy period
   `LBPE_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall))

   `LBPE_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)

   `LBPE_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
                     $stable(rsp_lamp_mask) && $stable(rsp_pattern_accepted))

endmodule

bind led_blink_pattern_engine_top lbpe_checker u_lbpe_checker (.*);
